// ===== sv/asw_pkg.sv =====
// ----------------------------------------------------------------------------
// asw_pkg
// Shared constants for the steering weight generator: CORDIC gain, angle
// table, fixed-point widths, 1/(2*pi) scale and wavenumber reset value.
// ----------------------------------------------------------------------------
package asw_pkg;

  localparam int unsigned AngW   = 32;
  localparam int unsigned CrdW   = 34;
  localparam int unsigned PosW   = 24;
  localparam int unsigned WtW    = 16;
  localparam int unsigned KvecW  = 34;
  localparam int unsigned DmW    = 40;
  localparam int unsigned CycW   = 48;
  localparam int unsigned TabLen = 24;

  localparam logic signed [CrdW-1:0] GainQ30  = 34'sd652032874;
  localparam logic [31:0]            Inv2PiQ32 = 32'd683565276;
  localparam logic [31:0]            WavenumberRst = 32'd411775;

  typedef logic [AngW-1:0] atan_tab_t [TabLen];

  localparam atan_tab_t AtanTurn = '{
    32'd536870912, 32'd316933406, 32'd167458907, 32'd85004756,
    32'd42667331,  32'd21354465,  32'd10679838,  32'd5340245,
    32'd2670163,   32'd1335087,   32'd667544,    32'd333772,
    32'd166886,    32'd83443,     32'd41722,     32'd20861,
    32'd10430,     32'd5215,      32'd2608,      32'd1304,
    32'd652,       32'd326,       32'd163,       32'd81
  };

endpackage

// ===== sv/asw_if.sv =====
// ----------------------------------------------------------------------------
// asw_in_if / asw_out_if
// Valid/ready channels carrying element words and weight words.
// ----------------------------------------------------------------------------
interface asw_in_if;
  logic                            valid;
  logic                            ready;
  logic [15:0]                     scan_theta;
  logic [15:0]                     scan_phi;
  logic signed [23:0]              pos_x;
  logic signed [23:0]              pos_y;
  logic signed [23:0]              pos_z;
  logic                            last_in;
  modport source (output valid, scan_theta, scan_phi, pos_x, pos_y, pos_z, last_in,
                  input ready);
  modport sink   (input valid, scan_theta, scan_phi, pos_x, pos_y, pos_z, last_in,
                  output ready);
endinterface

interface asw_out_if;
  logic               valid;
  logic               ready;
  logic signed [15:0] weight_re;
  logic signed [15:0] weight_im;
  logic               last_out;
  modport source (output valid, weight_re, weight_im, last_out, input ready);
  modport sink   (input valid, weight_re, weight_im, last_out, output ready);
endinterface

// ===== sv/array_steering_weight_generator_unit.sv =====
// ----------------------------------------------------------------------------
// array_steering_weight_generator_unit
// Phased-array steering weights: scan angles and element position in,
// complex Q1.15 weight out.
// Throughput: one word per cycle while the output word is not waiting.
// The whole pipeline advances together; it holds while the output word waits.
// Reset clears all valid bits and loads the wavenumber reset value.
// ----------------------------------------------------------------------------
module array_steering_weight_generator_unit
  import asw_pkg::*;
#(
  parameter int unsigned CORDIC_STAGES = 16
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [31:0] cfg_wdata_i,
  asw_in_if.sink      req_i,
  asw_out_if.source   rsp_o
);

  localparam logic [63:0] CycRst = (64'(WavenumberRst) * 64'(Inv2PiQ32) + 64'd32768) >> 16;

  logic            en;
  logic [31:0]     wn_q;
  logic [CycW-1:0] cyc_q;
  logic [63:0]     cyc_full;

  logic                   th_v, ph_v, ang_v, w_v;
  logic signed [AngW-1:0] ct, st, cp, sp, wc, ws;
  logic [2*PosW-1:0]      th_side;
  logic [PosW:0]          ph_side;
  logic [AngW-1:0]        turn;
  logic                   ph_last, w_last, t_v, t_last;

  logic signed [AngW:0]   rc, rs;
  logic signed [17:0]     qc, qs;

  assign en          = !rsp_o.valid || rsp_o.ready;
  assign req_i.ready = en;
  assign cyc_full    = 64'(wn_q) * 64'(Inv2PiQ32) + 64'd32768;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wn_q  <= WavenumberRst;
      cyc_q <= CycRst[CycW-1:0];
    end else begin
      if (cfg_we_i) begin
        wn_q <= cfg_wdata_i;
      end
      cyc_q <= cyc_full[CycW+15:16];
    end
  end

  asw_cordic #(.STAGES(CORDIC_STAGES), .SIDE_W(2*PosW)) u_theta (
    .clk_i, .rst_ni, .en_i(en),
    .valid_i(req_i.valid && en),
    .angle_i({req_i.scan_theta, 16'd0}),
    .side_i({req_i.pos_x, req_i.pos_y}),
    .valid_o(th_v), .cos_o(ct), .sin_o(st), .side_o(th_side)
  );

  asw_cordic #(.STAGES(CORDIC_STAGES), .SIDE_W(PosW+1)) u_phi (
    .clk_i, .rst_ni, .en_i(en),
    .valid_i(req_i.valid && en),
    .angle_i({req_i.scan_phi, 16'd0}),
    .side_i({req_i.pos_z, req_i.last_in}),
    .valid_o(ph_v), .cos_o(cp), .sin_o(sp), .side_o(ph_side)
  );

  assign ang_v   = th_v && ph_v;
  assign ph_last = ph_side[0];

  asw_phase u_phase (
    .clk_i, .rst_ni, .en_i(en),
    .valid_i(ang_v),
    .ct_i(ct), .st_i(st), .cp_i(cp), .sp_i(sp),
    .px_i(th_side[2*PosW-1:PosW]),
    .py_i(th_side[PosW-1:0]),
    .pz_i(ph_side[PosW:1]),
    .last_i(ph_last),
    .cyc_i(cyc_q),
    .valid_o(t_v), .turn_o(turn), .last_o(t_last)
  );

  asw_cordic #(.STAGES(CORDIC_STAGES), .SIDE_W(1)) u_weight (
    .clk_i, .rst_ni, .en_i(en),
    .valid_i(t_v), .angle_i(turn), .side_i(t_last),
    .valid_o(w_v), .cos_o(wc), .sin_o(ws), .side_o(w_last)
  );

  // round to Q1.15 and clamp
  assign rc = (AngW+1)'(wc) + 33'sd16384;
  assign rs = (AngW+1)'(ws) + 33'sd16384;
  assign qc = rc[AngW:15];
  assign qs = rs[AngW:15];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rsp_o.valid <= 1'b0;
    end else if (en) begin
      rsp_o.valid <= w_v;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      rsp_o.weight_re <= (qc > 18'sd32767) ? 16'sh7fff :
                         (qc < -18'sd32768) ? 16'sh8000 : qc[WtW-1:0];
      rsp_o.weight_im <= (qs > 18'sd32767) ? 16'sh7fff :
                         (qs < -18'sd32768) ? 16'sh8000 : qs[WtW-1:0];
      rsp_o.last_out  <= w_last;
    end
  end

endmodule

// ===== sv/asw_cordic.sv =====
// ----------------------------------------------------------------------------
// asw_cordic
// Pipelined rotation-mode CORDIC: turn angle in, cos and sin out in Q2.30.
// One fold register plus one register per iteration; side data rides along.
// ----------------------------------------------------------------------------
module asw_cordic
  import asw_pkg::*;
#(
  parameter int unsigned STAGES = 16,
  parameter int unsigned SIDE_W = 1
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   en_i,
  input  logic                   valid_i,
  input  logic [AngW-1:0]        angle_i,
  input  logic [SIDE_W-1:0]      side_i,
  output logic                   valid_o,
  output logic signed [AngW-1:0] cos_o,
  output logic signed [AngW-1:0] sin_o,
  output logic [SIDE_W-1:0]      side_o
);

  logic                   v_q [STAGES+1];
  logic signed [CrdW-1:0] x_q [STAGES+1];
  logic signed [CrdW-1:0] y_q [STAGES+1];
  logic signed [CrdW-1:0] z_q [STAGES+1];
  logic [SIDE_W-1:0]      s_q [STAGES+1];

  logic                   fold;
  logic [AngW-1:0]        rot;
  logic [AngW-1:0]        plus_q;

  assign plus_q = angle_i + 32'h4000_0000;
  assign fold   = plus_q[AngW-1];
  assign rot    = fold ? (angle_i ^ 32'h8000_0000) : angle_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q[0] <= 1'b0;
    end else if (en_i) begin
      v_q[0] <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      x_q[0] <= fold ? -GainQ30 : GainQ30;
      y_q[0] <= '0;
      z_q[0] <= CrdW'($signed(rot));
      s_q[0] <= side_i;
    end
  end

  for (genvar i = 0; i < STAGES; i++) begin : g_stage
    logic signed [CrdW-1:0] at;
    assign at = $signed({2'b00, AtanTurn[i]});

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        v_q[i+1] <= 1'b0;
      end else if (en_i) begin
        v_q[i+1] <= v_q[i];
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        if (!z_q[i][CrdW-1]) begin
          x_q[i+1] <= x_q[i] - (y_q[i] >>> i);
          y_q[i+1] <= y_q[i] + (x_q[i] >>> i);
          z_q[i+1] <= z_q[i] - at;
        end else begin
          x_q[i+1] <= x_q[i] + (y_q[i] >>> i);
          y_q[i+1] <= y_q[i] - (x_q[i] >>> i);
          z_q[i+1] <= z_q[i] + at;
        end
        s_q[i+1] <= s_q[i];
      end
    end
  end

  assign valid_o = v_q[STAGES];
  assign cos_o   = x_q[STAGES][AngW-1:0];
  assign sin_o   = y_q[STAGES][AngW-1:0];
  assign side_o  = s_q[STAGES];

endmodule

// ===== sv/asw_phase.sv =====
// ----------------------------------------------------------------------------
// asw_phase
// Unit vector, dot product with the element position and phase in turns.
// Five register stages: angle products, position products, dot product, phase product halves and turn.
// ----------------------------------------------------------------------------
module asw_phase
  import asw_pkg::*;
(
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   en_i,
  input  logic                   valid_i,
  input  logic signed [AngW-1:0] ct_i,
  input  logic signed [AngW-1:0] st_i,
  input  logic signed [AngW-1:0] cp_i,
  input  logic signed [AngW-1:0] sp_i,
  input  logic signed [PosW-1:0] px_i,
  input  logic signed [PosW-1:0] py_i,
  input  logic signed [PosW-1:0] pz_i,
  input  logic                   last_i,
  input  logic [CycW-1:0]        cyc_i,
  output logic                   valid_o,
  output logic [AngW-1:0]        turn_o,
  output logic                   last_o
);

  localparam int unsigned MulW = KvecW + PosW;
  localparam int unsigned DotW = MulW + 2;
  localparam int unsigned HalfW = CycW / 2;

  logic [4:0] v_q;
  logic [4:0] l_q;

  logic signed [2*AngW-1:0] pxx, pxy;
  logic signed [KvecW-1:0]  kx_q, ky_q, kz_q;
  logic signed [PosW-1:0]   px_q, py_q, pz_q;
  logic signed [MulW-1:0]   mx_q, my_q, mz_q;
  logic signed [DotW-1:0]   dot;
  logic signed [DmW-1:0]    dm_q;
  logic signed [64:0]       pl_full, ph_full;
  logic [61:0]              pl_q;
  logic [61-HalfW:0]        ph_q;
  logic [61:0]              prod;

  assign pxx = st_i * cp_i;
  assign pxy = st_i * sp_i;
  assign dot = DotW'(mx_q) + DotW'(my_q) + DotW'(mz_q);
  assign pl_full = $signed({1'b0, cyc_i[HalfW-1:0]}) * dm_q;
  assign ph_full = $signed({1'b0, cyc_i[CycW-1:HalfW]}) * dm_q;
  assign prod = pl_q + {ph_q, {HalfW{1'b0}}};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else if (en_i) begin
      v_q <= {v_q[3:0], valid_i};
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      l_q    <= {l_q[3:0], last_i};
      kx_q   <= pxx[2*AngW-1:30];
      ky_q   <= pxy[2*AngW-1:30];
      kz_q   <= KvecW'(ct_i);
      px_q   <= px_i;
      py_q   <= py_i;
      pz_q   <= pz_i;
      mx_q   <= kx_q * px_q;
      my_q   <= ky_q * py_q;
      mz_q   <= kz_q * pz_q;
      dm_q   <= dot[DotW-1:20];
      pl_q   <= pl_full[61:0];
      ph_q   <= ph_full[61-HalfW:0];
      turn_o <= 32'd0 - prod[61:30];
    end
  end

  assign valid_o = v_q[4];
  assign last_o  = l_q[4];

endmodule

// ===== dv/array_steering_weight_generator_unit_test.sv =====
// ----------------------------------------------------------------------------
// array_steering_weight_generator_unit_test
// Drives element words through the steering weight generator under several
// wavenumber settings and handshake idling patterns, predicts each weight
// with a bit-exact CORDIC model and checks every output word in order.
// ----------------------------------------------------------------------------
module array_steering_weight_generator_unit_test
  import asw_pkg::*;
();

  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned Stages   = 16;
  localparam int unsigned Latency  = 2 * (Stages + 1) + 6;
  localparam longint      CycLimit = 400000;

  typedef struct packed {
    logic [15:0]        theta;
    logic [15:0]        phi;
    logic signed [23:0] px;
    logic signed [23:0] py;
    logic signed [23:0] pz;
    logic               last;
  } elem_t;

  typedef struct packed {
    logic signed [15:0] re;
    logic signed [15:0] im;
    logic               last;
  } weight_t;

  logic        clk_i;
  logic        rst_ni;
  logic        cfg_we_i;
  logic [31:0] cfg_wdata_i;

  asw_in_if  req_if ();
  asw_out_if rsp_if ();

  array_steering_weight_generator_unit #(.CORDIC_STAGES(Stages)) dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .req_i       (req_if.sink),
    .rsp_o       (rsp_if.source)
  );

  elem_t   elem_q[$];
  weight_t weight_q[$];
  logic [31:0] k0;
  int unsigned src_idle_pct;
  int unsigned snk_stall_pct;
  bit          failed;
  longint      cyc_cnt;

  function automatic longint floor_shr(longint v, int unsigned s);
    return v >>> s;
  endfunction

  function automatic void rotate(input logic [31:0] a, output longint c, output longint s);
    longint x, y, z, nx;
    logic [31:0] r;
    logic [31:0] t;
    x = GainQ30;
    y = 0;
    r = a;
    t = a + 32'h4000_0000;
    if (t[31]) begin
      x = -GainQ30;
      r = a ^ 32'h8000_0000;
    end
    z = longint'($signed(r));
    for (int i = 0; i < Stages && i < TabLen; i++) begin
      if (z >= 0) begin
        nx = x - floor_shr(y, i);
        y  = y + floor_shr(x, i);
        z  = z - longint'(AtanTurn[i]);
      end else begin
        nx = x + floor_shr(y, i);
        y  = y - floor_shr(x, i);
        z  = z + longint'(AtanTurn[i]);
      end
      x = nx;
    end
    c = x;
    s = y;
  endfunction

  function automatic logic signed [15:0] round_q15(longint v);
    longint q;
    q = floor_shr(v + 16384, 15);
    if (q > 32767) q = 32767;
    if (q < -32768) q = -32768;
    return q[15:0];
  endfunction

  function automatic weight_t steer_weight(elem_t e, logic [31:0] kw);
    longint st, ct, sp, cp, kx, ky, dot, dm, wc, ws;
    logic [63:0] cyc, prod;
    logic [31:0] turn;
    weight_t w;
    rotate({e.theta, 16'h0}, ct, st);
    rotate({e.phi, 16'h0}, cp, sp);
    kx  = floor_shr(st * cp, 30);
    ky  = floor_shr(st * sp, 30);
    dot = kx * longint'(e.px) + ky * longint'(e.py) + ct * longint'(e.pz);
    dm  = floor_shr(dot, 20);
    cyc = (64'(kw) * 64'(Inv2PiQ32) + 64'd32768) >> 16;
    prod = cyc * 64'(dm);
    turn = 32'd0 - prod[61:30];
    rotate(turn, wc, ws);
    w.re   = round_q15(wc);
    w.im   = round_q15(ws);
    w.last = e.last;
    return w;
  endfunction

  function automatic logic signed [23:0] rand_pos();
    case ($urandom_range(0, 3))
      0: return $urandom_range(0, 1) ? 24'sh7FFFFF : 24'sh800000;
      1: return 24'($signed($urandom_range(0, 4096)) - 2048);
      default: return 24'($urandom);
    endcase
  endfunction

  function automatic elem_t rand_elem();
    elem_t e;
    e.theta = $urandom_range(0, 3) == 0 ? 16'({$urandom_range(0, 7), 13'h0}) : 16'($urandom);
    e.phi   = $urandom_range(0, 3) == 0 ? 16'({$urandom_range(0, 7), 13'h0}) : 16'($urandom);
    e.px    = rand_pos();
    e.py    = rand_pos();
    e.pz    = rand_pos();
    e.last  = $urandom_range(0, 7) == 0;
    return e;
  endfunction

  initial begin
    clk_i = 1'b0;
    forever #1 clk_i = ~clk_i;
  end

  // driver
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      req_if.valid      <= 1'b0;
      req_if.scan_theta <= '0;
      req_if.scan_phi   <= '0;
      req_if.pos_x      <= '0;
      req_if.pos_y      <= '0;
      req_if.pos_z      <= '0;
      req_if.last_in    <= 1'b0;
    end else if (!req_if.valid || req_if.ready) begin
      if (req_if.valid) begin
        weight_q = {weight_q, steer_weight({req_if.scan_theta, req_if.scan_phi, req_if.pos_x,
                                            req_if.pos_y, req_if.pos_z, req_if.last_in}, k0)};
      end
      if (elem_q.size() != 0 && $urandom_range(0, 99) >= src_idle_pct) begin
        elem_t e;
        e = elem_q.pop_front();
        req_if.valid      <= 1'b1;
        req_if.scan_theta <= e.theta;
        req_if.scan_phi   <= e.phi;
        req_if.pos_x      <= e.px;
        req_if.pos_y      <= e.py;
        req_if.pos_z      <= e.pz;
        req_if.last_in    <= e.last;
      end else begin
        req_if.valid <= 1'b0;
      end
    end
  end

  // monitor
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rsp_if.ready <= 1'b0;
      cyc_cnt      <= 0;
    end else begin
      cyc_cnt <= cyc_cnt + 1;
      if (rsp_if.valid && rsp_if.ready) begin
        if (weight_q.size() == 0) begin
          $display("%0t: unexpected word re=%0d im=%0d last=%0b", $time,
                   rsp_if.weight_re, rsp_if.weight_im, rsp_if.last_out);
          failed <= 1'b1;
        end else begin
          weight_t w;
          w = weight_q.pop_front();
          if (w.re !== rsp_if.weight_re || w.im !== rsp_if.weight_im ||
              w.last !== rsp_if.last_out) begin
            $display("%0t: mismatch expected re=%0d im=%0d last=%0b actual re=%0d im=%0d last=%0b",
                     $time, w.re, w.im, w.last, rsp_if.weight_re, rsp_if.weight_im,
                     rsp_if.last_out);
            failed <= 1'b1;
          end
        end
      end
      rsp_if.ready <= $urandom_range(0, 99) >= snk_stall_pct;
    end
  end

  task automatic drain();
    while (elem_q.size() != 0 || req_if.valid || weight_q.size() != 0) @(posedge clk_i);
    repeat (Latency + 4) @(posedge clk_i);
  endtask

  task automatic set_k0(logic [31:0] v);
    @(posedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= v;
    k0          = v;
    @(posedge clk_i);
    cfg_we_i    <= 1'b0;
  endtask

  initial begin
    logic [31:0] k0_set [6];
    elem_t e;
    k0_set = '{32'd411775, 32'hFFFF_FFFF, 32'd0, 32'd1, 32'h0100_0000, 32'h8000_0000};
    failed        = 1'b0;
    src_idle_pct  = 0;
    snk_stall_pct = 0;
    k0            = WavenumberRst;
    cfg_we_i      = 1'b0;
    cfg_wdata_i   = '0;
    rst_ni        = 1'b0;
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;

    // directed: reset wavenumber, field extremes and the cardinal angles
    for (int i = 0; i < 8; i++) begin
      e.theta = 16'(i * 16'h2000);
      e.phi   = 16'((7 - i) * 16'h2000);
      e.px    = i[0] ? 24'sh7FFFFF : 24'sh800000;
      e.py    = i[1] ? 24'sh7FFFFF : 24'sh800000;
      e.pz    = i[2] ? 24'sh800000 : 24'sh7FFFFF;
      e.last  = i[0];
      elem_q  = {elem_q, e};
    end
    elem_q = {elem_q, elem_t'{16'hFFFF, 16'hFFFF, 24'sh0, 24'sh0, 24'sh0, 1'b1}};
    elem_q = {elem_q, elem_t'{16'h0000, 16'h0000, 24'sh000001, 24'shFFFFFF, 24'sh100000,
                              1'b0}};
    elem_q = {elem_q, elem_t'{16'h4000, 16'h4000, 24'sh155555, 24'shAAAAAA, 24'sh555555,
                              1'b1}};
    drain();

    for (int ph = 0; ph < 12; ph++) begin
      set_k0(ph < 6 ? k0_set[ph] : $urandom);
      case (ph % 4)
        0: begin src_idle_pct = 0;  snk_stall_pct = 0;  end
        1: begin src_idle_pct = 47; snk_stall_pct = 0;  end
        2: begin src_idle_pct = 0;  snk_stall_pct = 47; end
        default: begin src_idle_pct = 31; snk_stall_pct = 31; end
      endcase
      for (int i = 0; i < 150; i++) elem_q = {elem_q, rand_elem()};
      drain();
    end
    if (!failed) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

  always @(posedge clk_i) begin
    if (cyc_cnt > CycLimit) begin
      $display("[FAIL] regression broken");
      $finish;
    end
  end

endmodule
